FILE: sv/sdac_pkg.sv
// Shared constants and the decimal place weight table for the decimal text converter.
package sdac_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned MAG_W      = 31;
  localparam int unsigned WEIGHT_W   = 30;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned NUM_PLACES = 10;
  localparam int unsigned PLACE_W    = 4;
  localparam int unsigned DIGIT_W    = 4;

  localparam logic [PLACE_W-1:0]  LAST_PLACE  = PLACE_W'(NUM_PLACES - 1);
  localparam logic [DIGIT_W-1:0]  MAX_DIGIT   = DIGIT_W'(9);
  localparam logic [CHAR_W-1:0]   CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]   CHAR_MINUS  = CHAR_W'(45);
  localparam logic [CHAR_W-1:0]   CHAR_NONE   = CHAR_W'(0);
  localparam logic [CHAR_W-1:0]   CHAR_NINE   = CHAR_W'(57);
  localparam logic [VALUE_W-1:0]  VALUE_MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

  // Weight of each decimal place, most significant place first.
  function automatic logic [WEIGHT_W-1:0] place_weight(input logic [PLACE_W-1:0] idx);
    logic [WEIGHT_W-1:0] w;
    unique case (idx)
      4'd0:    w = WEIGHT_W'(1000000000);
      4'd1:    w = WEIGHT_W'(100000000);
      4'd2:    w = WEIGHT_W'(10000000);
      4'd3:    w = WEIGHT_W'(1000000);
      4'd4:    w = WEIGHT_W'(100000);
      4'd5:    w = WEIGHT_W'(10000);
      4'd6:    w = WEIGHT_W'(1000);
      4'd7:    w = WEIGHT_W'(100);
      4'd8:    w = WEIGHT_W'(10);
      default: w = WEIGHT_W'(1);
    endcase
    return w;
  endfunction

endpackage

FILE: sv/sdac_csub.sv
// Shared compare-and-subtract unit: tests the remaining magnitude against one place weight.
module sdac_csub
  import sdac_pkg::*;
(
  input  logic [MAG_W-1:0]    mag,
  input  logic [WEIGHT_W-1:0] weight,
  output logic                ge,
  output logic [MAG_W-1:0]    diff
);

  logic [MAG_W:0] sub_full;

  // One wide subtract; the borrow out doubles as the compare result.
  assign sub_full = {1'b0, mag} - {1'b0, {(MAG_W-WEIGHT_W){1'b0}}, weight};
  assign ge       = ~sub_full[MAG_W];
  assign diff     = sub_full[MAG_W-1:0];

endmodule

FILE: sv/signed_int_to_decimal_ascii_core.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per output item.
// Sequence: after acceptance, the SIGN state (if negative) or the INV state (for the most
// negative integer) loads the output register, once it can take an item; each digit then
// follows from the SUB and EMIT states of its place. A new integer is taken only once the last
// is done, since the shared subtract unit serves every place in turn.
// Reset: rst_n is synchronous and active low; it idles the sequencer and empties the output.
module signed_int_to_decimal_ascii_core
  import sdac_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CHAR_W-1:0]         out_text_char,
  output logic                      out_last,
  output logic                      out_invalid
);

  // Sequencer states. SUB drives the shared unit; EMIT hands a digit to the output register, or drops a leading zero.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_SUB  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic [PLACE_W-1:0]  place_r, place_nxt;
  logic [DIGIT_W-1:0]  digit_r, digit_nxt;
  logic                started_r, started_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_inv_r, out_inv_nxt;

  logic                unit_ge;
  logic [MAG_W-1:0]    unit_diff;
  logic [VALUE_W-1:0]  raw_value;
  logic [VALUE_W-1:0]  neg_value;
  logic                accept;
  logic                can_load;
  logic                emit_now;
  logic                last_place;

  sdac_csub u_csub (
    .mag    (mag_r),
    .weight (place_weight(place_r)),
    .ge     (unit_ge),
    .diff   (unit_diff)
  );

  assign raw_value  = $unsigned(in_value);
  assign neg_value  = {VALUE_W{1'b0}} - raw_value;
  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid & in_ready;
  // The output register may take a new character when it is empty or is being drained.
  assign can_load   = ~out_valid_r | out_ready;
  assign last_place = (place_r == LAST_PLACE);
  // A digit is printed once a nonzero digit has been seen, and the units digit always is,
  // which is how zero comes out as a single '0'.
  assign emit_now   = started_r | (digit_r != {DIGIT_W{1'b0}}) | last_place;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    place_nxt     = place_r;
    digit_nxt     = digit_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_inv_nxt   = out_inv_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          place_nxt   = {PLACE_W{1'b0}};
          digit_nxt   = {DIGIT_W{1'b0}};
          started_nxt = 1'b0;
          mag_nxt     = raw_value[VALUE_W-1] ? neg_value[MAG_W-1:0] : raw_value[MAG_W-1:0];
          if (raw_value == VALUE_MOST_NEG) begin
            state_nxt = ST_INV;
          end else if (raw_value[VALUE_W-1]) begin
            state_nxt = ST_SIGN;
          end else begin
            state_nxt = ST_SUB;
          end
        end
      end
      ST_INV: begin
        // The most negative integer has no printable magnitude: one flagged item, no text.
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_NONE;
          out_last_nxt  = 1'b1;
          out_inv_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          out_inv_nxt   = 1'b0;
          state_nxt     = ST_SUB;
        end
      end
      ST_SUB: begin
        // Repeated subtraction of the current place weight, capped at nine per place.
        if (unit_ge && (digit_r != MAX_DIGIT)) begin
          mag_nxt   = unit_diff;
          digit_nxt = digit_r + DIGIT_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_now || can_load) begin
          if (emit_now) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_ZERO + CHAR_W'(digit_r);
            out_last_nxt  = last_place;
            out_inv_nxt   = 1'b0;
          end
          started_nxt = started_r | emit_now;
          digit_nxt   = {DIGIT_W{1'b0}};
          if (last_place) begin
            state_nxt = ST_IDLE;
          end else begin
            place_nxt = place_r + PLACE_W'(1);
            state_nxt = ST_SUB;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    place_r    <= place_nxt;
    digit_r    <= digit_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_inv_r  <= out_inv_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last      = out_last_r;
  assign out_invalid   = out_inv_r;

endmodule

FILE: sv/sdac_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
module sdac_checker
  import sdac_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [CHAR_W-1:0]         out_text_char,
  input logic                      out_last,
  input logic                      out_invalid
);

  // A stalled output item keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_char) && $stable(out_last)
    && $stable(out_invalid))
    else $error("output item changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item in progress");

  a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_last && (out_text_char == CHAR_NONE))
    else $error("invalid item not a lone empty final item");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |-> (out_text_char == CHAR_MINUS)
    || ((out_text_char >= CHAR_ZERO) && (out_text_char <= CHAR_NINE)))
    else $error("character outside minus and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_text_char == CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as final character");

endmodule

bind signed_int_to_decimal_ascii_core sdac_checker u_sdac_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_text_char (out_text_char),
  .out_last      (out_last),
  .out_invalid   (out_invalid)
);
